// ----- hdl/itd_pkg.sv -----
// shared types and constants for the impact and tilt event detector
package itd_pkg;

    // gravity, 9.80665 m/s^2 rounded to q8.8
    localparam logic [15:0] GRAVITY_Q88 = 16'd2511;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int RES_DEPTH  = 4;

    localparam logic [3:0] STREAK_MAX = 4'd15;

    // register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMPACT_THR = 3'd0,
        REG_TILT_THR   = 3'd1,
        REG_IMPACT_CD  = 3'd2,
        REG_TILT_CD    = 3'd3,
        REG_MIN_STREAK = 3'd4
    } cfg_reg_t;

    // result kinds
    typedef enum logic {
        KIND_IMPACT = 1'b0,
        KIND_THEFT  = 1'b1
    } event_kind_t;

    typedef struct packed {
        logic [15:0] impact_thr;
        logic [15:0] tilt_threshold;
        logic [23:0] impact_cooldown;
        logic [23:0] tilt_cooldown;
        logic [3:0]  min_streak;
    } cfg_t;

    typedef struct packed {
        logic        sample_ok;
        logic [15:0] accel_x;
        logic [15:0] accel_z;
        logic [47:0] now_us;
    } sample_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [15:0] magnitude;
        logic [47:0] event_time;
        logic        last_of_run;
    } result_t;

    // up to two results from one sample, first one in res0
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res1;
        result_t    res0;
    } push_t;

endpackage

// ----- hdl/impact_and_tilt_event_detector.sv -----
// top level of the impact and tilt event detector
//
// one accelerometer sample comes in per request on the s_ channel; a sample
// with s_tuser (sample_ok) low is dropped and leaves all state untouched.
// each good sample gives zero, one or two events on the m_ channel: an
// impact (m_tuser = 0) when |dx| reaches the threshold outside the impact
// cooldown, then a theft (m_tuser = 1) when |z - g| has deviated for the
// minimum streak outside the tilt cooldown. m_tlast marks the last event of
// a sample.
// the events of a sample are written into the result queue, which drives m_tvalid.
// throughput: one sample per cycle while samples average at most one event and
// m_tready stays high; the detection is a single stage of subtracts and compares
// between the input register and a four-entry result queue, and the output drains
// one event per cycle, so a run of samples with two events each makes the input
// wait for the queue to drain.
// the input register waits only while the queue has fewer than two free
// slots, so a stalled receiver stops s_tready once more than two events wait.
// reset (aresetn low, synchronous) loads the default thresholds and
// cooldowns, clears the history and empties the queue.
// configuration writes via cfg_we/cfg_addr/cfg_wdata are taken without a handshake.
module impact_and_tilt_event_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [itd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [itd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [79:0]                     s_tdata,  // accel_x, accel_z, now_us
    input  logic                            s_tuser,  // sample_ok
    // event output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,  // magnitude, event_time
    output logic                            m_tuser,  // event_kind
    output logic                            m_tlast   // last_of_run
);
    import itd_pkg::*;

    cfg_t    cfg;
    push_t   push;
    result_t out_res;
    logic    room_for_two;
    logic    advance;

    // input register, holds one sample in front of the detection logic
    logic    in_valid_reg, in_valid_next;
    sample_t in_item_reg,  in_item_next;

    itd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // the sample moves on only if the queue can hold both possible events
    assign advance  = in_valid_reg && room_for_two;
    assign s_tready = !in_valid_reg || room_for_two;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready) begin
            in_valid_next          = s_tvalid;
            in_item_next.sample_ok = s_tuser;
            in_item_next.accel_x   = s_tdata[15:0];
            in_item_next.accel_z   = s_tdata[31:16];
            in_item_next.now_us    = s_tdata[79:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_item_reg <= in_item_next;
    end

    itd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_item_reg),
        .push    (push)
    );

    itd_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (out_res)
    );

    assign m_tdata = {out_res.event_time, out_res.magnitude};
    assign m_tuser = out_res.event_kind;
    assign m_tlast = out_res.last_of_run;

endmodule

// ----- hdl/itd_cfg.sv -----
// configuration register file
module itd_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [itd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [itd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output itd_pkg::cfg_t                    cfg
);
    import itd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_IMPACT_THR: cfg_next.impact_thr      = cfg_wdata[15:0];
                REG_TILT_THR:   cfg_next.tilt_threshold  = cfg_wdata[15:0];
                REG_IMPACT_CD:  cfg_next.impact_cooldown = cfg_wdata[23:0];
                REG_TILT_CD:    cfg_next.tilt_cooldown   = cfg_wdata[23:0];
                REG_MIN_STREAK: cfg_next.min_streak      = cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.impact_thr       <= 16'd6400;
            cfg_reg.tilt_threshold   <= 16'd3072;
            cfg_reg.impact_cooldown  <= 24'd1000000;
            cfg_reg.tilt_cooldown    <= 24'd3000000;
            cfg_reg.min_streak       <= 4'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/itd_core.sv -----
// detection logic and per-sample state
module itd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  itd_pkg::cfg_t    cfg,
    input  logic             advance,
    input  itd_pkg::sample_t item,
    output itd_pkg::push_t   push
);
    import itd_pkg::*;

    logic [15:0] previous_x_reg,       previous_x_next;
    logic        have_previous_reg,    have_previous_next;
    logic [3:0]  deviation_streak_reg, deviation_streak_next;
    logic [47:0] last_impact_time_reg, last_impact_time_next;
    logic [47:0] last_tilt_time_reg,   last_tilt_time_next;

    logic [16:0] dx;
    logic [15:0] jerk;
    logic [16:0] dz;
    logic [15:0] vdev;
    logic [47:0] impact_elapsed;
    logic [47:0] tilt_elapsed;
    logic        impact_cd_done;
    logic        tilt_cd_done;
    logic        deviating;
    logic [3:0]  streak_inc;
    logic        fire_impact;
    logic        fire_theft;
    logic        take;
    result_t     impact_res;
    result_t     theft_res;

    always_comb begin
        take = advance && item.sample_ok;

        dx   = {item.accel_x[15], item.accel_x} - {previous_x_reg[15], previous_x_reg};
        jerk = dx[16] ? 16'(-dx) : dx[15:0];
        dz   = {item.accel_z[15], item.accel_z} - {1'b0, GRAVITY_Q88};
        vdev = dz[16] ? 16'(-dz) : dz[15:0];

        // elapsed time wraps modulo 2^48, cooldown is only 24 bits wide
        impact_elapsed = item.now_us - last_impact_time_reg;
        tilt_elapsed   = item.now_us - last_tilt_time_reg;
        impact_cd_done = (|impact_elapsed[47:24]) ||
                         (impact_elapsed[23:0] > cfg.impact_cooldown);
        tilt_cd_done   = (|tilt_elapsed[47:24]) ||
                         (tilt_elapsed[23:0] > cfg.tilt_cooldown);

        deviating  = vdev >= cfg.tilt_threshold;
        streak_inc = (deviation_streak_reg == STREAK_MAX) ? STREAK_MAX
                                                          : deviation_streak_reg + 4'd1;

        fire_impact = have_previous_reg && (jerk >= cfg.impact_thr) && impact_cd_done;
        fire_theft  = deviating && (streak_inc >= cfg.min_streak) && tilt_cd_done;

        previous_x_next       = previous_x_reg;
        have_previous_next    = have_previous_reg;
        deviation_streak_next = deviation_streak_reg;
        last_impact_time_next = last_impact_time_reg;
        last_tilt_time_next   = last_tilt_time_reg;
        if (take) begin
            previous_x_next    = item.accel_x;
            have_previous_next = 1'b1;
            if (fire_impact) begin
                last_impact_time_next = item.now_us;
            end
            if (fire_theft) begin
                last_tilt_time_next = item.now_us;
            end
            deviation_streak_next = (deviating && !fire_theft) ? streak_inc : 4'd0;
        end

        impact_res.event_kind  = KIND_IMPACT;
        impact_res.magnitude   = jerk;
        impact_res.event_time  = item.now_us;
        impact_res.last_of_run = !fire_theft;

        theft_res.event_kind   = KIND_THEFT;
        theft_res.magnitude    = vdev;
        theft_res.event_time   = item.now_us;
        theft_res.last_of_run  = 1'b1;

        // impact goes first when both fire
        push.res0 = fire_impact ? impact_res : theft_res;
        push.res1 = theft_res;
        if (take) begin
            push.cnt = {1'b0, fire_impact} + {1'b0, fire_theft};
        end else begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_x_reg       <= '0;
            have_previous_reg    <= 1'b0;
            deviation_streak_reg <= '0;
            last_impact_time_reg <= '0;
            last_tilt_time_reg   <= '0;
        end else begin
            previous_x_reg       <= previous_x_next;
            have_previous_reg    <= have_previous_next;
            deviation_streak_reg <= deviation_streak_next;
            last_impact_time_reg <= last_impact_time_next;
            last_tilt_time_reg   <= last_tilt_time_next;
        end
    end

endmodule

// ----- hdl/itd_fifo.sv -----
// small result queue, takes up to two results per cycle, gives one while out_ready is high
module itd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  itd_pkg::push_t    push,
    output logic              room_for_two,
    output logic              out_valid,
    input  logic              out_ready,
    output itd_pkg::result_t  out_res
);
    import itd_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    result_t          mem_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    always_comb begin
        pop          = out_valid && out_ready;
        wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
        count_next   = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    assign room_for_two = count_reg <= CNT_W'(RES_DEPTH - 2);
    assign out_valid    = count_reg != '0;
    assign out_res      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
